>>> src/lsdm_pkg.sv
// ----------------------------------------------------------------------------
// lsdm_pkg
// Shared types, codes and lane helpers for the load/store data memory.
// ----------------------------------------------------------------------------
package lsdm_pkg;

	// fixed field widths
	localparam int BYTE_ADDR_W = 18;
	localparam int DATA_W      = 32;
	localparam int SIZE_W      = 3;

	// action codes
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_STORE = 1'b1;

	// funct3 load codes
	localparam logic [SIZE_W-1:0] F3_LB  = 3'd0;
	localparam logic [SIZE_W-1:0] F3_LH  = 3'd1;
	localparam logic [SIZE_W-1:0] F3_LW  = 3'd2;
	localparam logic [SIZE_W-1:0] F3_LBU = 3'd4;
	localparam logic [SIZE_W-1:0] F3_LHU = 3'd5;

	// store width from funct3 bits 1:0
	localparam logic [1:0] ST_BYTE = 2'b00;
	localparam logic [1:0] ST_HALF = 2'b01;
	localparam logic [1:0] ST_WORD = 2'b10;
	localparam logic [1:0] ST_NONE = 2'b11;

	// controller states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD
	} lsdm_state_t;

	// controller to datapath
	typedef struct packed {
		logic clr_wr;     // write zero at the clear pointer
		logic acc_store;  // input beat is a store, write memory now
		logic acc_load;   // input beat is a load, read memory now
		logic out_load;   // format read word into the output register
	} lsdm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;   // clear pointer at the last word
		logic out_free;   // output register can take a beat this cycle
	} lsdm_status_t;

	// byte enables for a store
	function automatic logic [3:0] store_be(input logic [1:0] lane, input logic [1:0] sz);
		logic [3:0] be;
		be = 4'b0000;
		unique case (sz)
			ST_BYTE: be = 4'b0001 << lane;
			ST_HALF: be = lane[1] ? 4'b1100 : 4'b0011;
			ST_WORD: be = 4'b1111;
			ST_NONE: be = 4'b0000;
			default: be = 4'b0000;
		endcase
		return be;
	endfunction

	// store data replicated across lanes
	function automatic logic [DATA_W-1:0] store_lanes(input logic [1:0] sz,
		input logic [DATA_W-1:0] d);
		logic [DATA_W-1:0] w;
		w = d;
		unique case (sz)
			ST_BYTE: w = {4{d[7:0]}};
			ST_HALF: w = {2{d[15:0]}};
			ST_WORD: w = d;
			ST_NONE: w = d;
			default: w = d;
		endcase
		return w;
	endfunction

	// lane select and extension of a loaded word
	function automatic logic [DATA_W-1:0] load_format(input logic [DATA_W-1:0] word,
		input logic [1:0] lane, input logic [SIZE_W-1:0] code);
		logic [7:0]        b;
		logic [15:0]       h;
		logic [DATA_W-1:0] r;
		b = 8'h00;
		unique case (lane)
			2'd0: b = word[7:0];
			2'd1: b = word[15:8];
			2'd2: b = word[23:16];
			2'd3: b = word[31:24];
			default: b = 8'h00;
		endcase
		h = lane[1] ? word[31:16] : word[15:0];
		unique case (code)
			F3_LB:   r = {{24{b[7]}}, b};
			F3_LH:   r = {{16{h[15]}}, h};
			F3_LW:   r = word;
			F3_LBU:  r = {24'h000000, b};
			F3_LHU:  r = {16'h0000, h};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> src/lsdm_datapath.sv
// ----------------------------------------------------------------------------
// lsdm_datapath
// Data memory with byte enables, read register, clear pointer and output
// register.
// ----------------------------------------------------------------------------
module lsdm_datapath #(
	parameter int WORD_ADDR_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lsdm_pkg::lsdm_cmd_t                 cmd,
	output lsdm_pkg::lsdm_status_t              status,
	input  logic [lsdm_pkg::BYTE_ADDR_W-1:0]    byte_address,
	input  logic [lsdm_pkg::SIZE_W-1:0]         size_code,
	input  logic signed [lsdm_pkg::DATA_W-1:0]  store_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [lsdm_pkg::DATA_W-1:0]  load_data
);
	import lsdm_pkg::*;

	localparam int DEPTH = 1 << WORD_ADDR_BITS;

	logic [DATA_W-1:0]         mem [DEPTH];
	logic [WORD_ADDR_BITS-1:0] clr_q;
	logic [WORD_ADDR_BITS-1:0] req_idx;
	logic [WORD_ADDR_BITS-1:0] wr_idx;
	logic [3:0]                wr_be;
	logic [DATA_W-1:0]         wr_data;
	logic                      wr_en;
	logic [DATA_W-1:0]         rdata_q;
	logic [1:0]                lane_q;
	logic [SIZE_W-1:0]         code_q;
	logic                      out_valid_q;
	logic [DATA_W-1:0]         load_data_q;

	// word index wraps or zero-extends to the memory size
	assign req_idx = WORD_ADDR_BITS'(byte_address[BYTE_ADDR_W-1:2]);

	// write port: clearing pass or store
	assign wr_en   = cmd.clr_wr | cmd.acc_store;
	assign wr_idx  = cmd.clr_wr ? clr_q : req_idx;
	assign wr_be   = cmd.clr_wr ? 4'b1111 : store_be(byte_address[1:0], size_code[1:0]);
	assign wr_data = cmd.clr_wr ? '0 : store_lanes(size_code[1:0], store_data);

	// memory write with byte enables
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < 4; i++) begin
				if (wr_be[i]) begin
					mem[wr_idx][8*i +: 8] <= wr_data[8*i +: 8];
				end
			end
		end
	end

	// registered read with the load's lane and code
	always_ff @(posedge clk) begin
		if (cmd.acc_load) begin
			rdata_q <= mem[req_idx];
			lane_q  <= byte_address[1:0];
			code_q  <= size_code;
		end
	end

	// clear pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			load_data_q <= load_format(rdata_q, lane_q, code_q);
		end
	end

	assign status.clr_last = &clr_q;
	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;
	assign load_data       = load_data_q;

	// a new beat never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("output beat overwritten");

	// output beats appear only from a formatted load
	a_out_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.out_load))
		else $error("output beat without load");

	// clearing pass never shares the port with an access
	a_clr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> (!cmd.acc_store && !cmd.acc_load))
		else $error("access during clearing pass");

endmodule

>>> src/lsdm_ctrl.sv
// ----------------------------------------------------------------------------
// lsdm_ctrl
// Controller: clearing pass after reset, input acceptance and load sequencing.
// ----------------------------------------------------------------------------
module lsdm_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   action,
	input  lsdm_pkg::lsdm_status_t status,
	output lsdm_pkg::lsdm_cmd_t    cmd
);
	import lsdm_pkg::*;

	lsdm_state_t state_q;
	lsdm_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (action == ACT_STORE) begin
						cmd.acc_store = 1'b1;
					end else begin
						cmd.acc_load = 1'b1;
						state_d      = ST_LOAD;
					end
				end
			end
			ST_LOAD: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// only one command at a time
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("conflicting datapath commands");

	// a pending load waits while the output register is blocked
	a_load_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && !status.out_free) |=> (state_q == ST_LOAD))
		else $error("pending load dropped");

endmodule

>>> src/load_store_data_memory.sv
// ----------------------------------------------------------------------------
// load_store_data_memory
// RV32I load/store unit over a word-organized, byte-enabled data memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps the memory to zero, one word per cycle,
// holding in_stall high meanwhile. A store is written through the byte
// enables at the beat it is accepted, so stores run back to back. For a
// load the memory read is registered; then, once the output register is
// free, the byte or halfword is selected, extended and placed in the output
// register; the next input beat is accepted once that is done. A load result
// may wait in the output register while further stores are taken. The word
// index is byte_address bits 17:2, truncated or zero-extended to
// WORD_ADDR_BITS.
// ----------------------------------------------------------------------------
module load_store_data_memory #(
	parameter int WORD_ADDR_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                action,
	input  logic [lsdm_pkg::BYTE_ADDR_W-1:0]    byte_address,
	input  logic [lsdm_pkg::SIZE_W-1:0]         size_code,
	input  logic signed [lsdm_pkg::DATA_W-1:0]  store_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [lsdm_pkg::DATA_W-1:0]  load_data
);
	import lsdm_pkg::*;

	lsdm_cmd_t    cmd;
	lsdm_status_t status;

	// controller
	lsdm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath
	lsdm_datapath #(
		.WORD_ADDR_BITS (WORD_ADDR_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.byte_address (byte_address),
		.size_code    (size_code),
		.store_data   (store_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.load_data    (load_data)
	);

endmodule
